[hw/rtl/cpf_pkg.sv]
// shared types, constants and the divider step for the clip position and fade gain block
package cpf_pkg;

  localparam int FRAME_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int GAIN_W     = FRAC_W + 8;
  localparam int FADE_W     = FRAC_W + 1;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int DIV_STAGES = FRAME_W;

  localparam logic [FADE_W-1:0] UNITY_FADE = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [GAIN_W-1:0] UNITY_GAIN = {8'd1, {FRAC_W{1'b0}}};

  typedef enum logic [2:0] {
    REG_CLIP_START      = 3'd0,
    REG_SOURCE_OFFSET   = 3'd1,
    REG_CLIP_LENGTH     = 3'd2,
    REG_LOOP_ENABLE     = 3'd3,
    REG_FADE_IN_LENGTH  = 3'd4,
    REG_FADE_OUT_LENGTH = 3'd5,
    REG_BUFFER_FRAMES   = 3'd6,
    REG_CLIP_GAIN       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [FRAME_W-1:0] clip_start;
    logic [FRAME_W-1:0] source_offset;
    logic [FRAME_W-1:0] clip_length;
    logic               loop_enable;
    logic [FRAME_W-1:0] fade_in_length;
    logic [FRAME_W-1:0] fade_out_length;
    logic [FRAME_W-1:0] buffer_frames;
    logic [GAIN_W-1:0]  clip_gain;
  } cfg_t;

  typedef struct packed {
    logic               silent;
    logic               wrap;
    logic               fin_use;
    logic               fout_use;
    logic [FRAME_W-1:0] rel;
    logic [FRAME_W-1:0] dvd;
    logic [FRAME_W-1:0] mod_rem;
    logic [FRAME_W-1:0] fin_rem;
    logic [FRAC_W-1:0]  fin_q;
    logic [FRAME_W-1:0] fout_rem;
    logic [FRAC_W-1:0]  fout_q;
  } item_t;

  // one restoring step of the loop modulo and, optionally, of both fade ratios
  function automatic item_t div_step(item_t it, cfg_t cfg, logic do_frac);
    logic [FRAME_W:0] r;
    item_t            o;
    o = it;
    r = {it.mod_rem, it.dvd[FRAME_W-1]};
    if (r >= {1'b0, cfg.clip_length}) begin
      r = r - {1'b0, cfg.clip_length};
    end
    o.mod_rem = r[FRAME_W-1:0];
    o.dvd     = {it.dvd[FRAME_W-2:0], 1'b0};
    if (do_frac) begin
      r = {it.fin_rem, 1'b0};
      if (r >= {1'b0, cfg.fade_in_length}) begin
        r       = r - {1'b0, cfg.fade_in_length};
        o.fin_q = {it.fin_q[FRAC_W-2:0], 1'b1};
      end else begin
        o.fin_q = {it.fin_q[FRAC_W-2:0], 1'b0};
      end
      o.fin_rem = r[FRAME_W-1:0];
      r = {it.fout_rem, 1'b0};
      if (r >= {1'b0, cfg.fade_out_length}) begin
        r        = r - {1'b0, cfg.fade_out_length};
        o.fout_q = {it.fout_q[FRAC_W-2:0], 1'b1};
      end else begin
        o.fout_q = {it.fout_q[FRAC_W-2:0], 1'b0};
      end
      o.fout_rem = r[FRAME_W-1:0];
    end
    return o;
  endfunction

endpackage

[hw/rtl/clip_position_fade_gain.sv]
// clip position and fade gain: top level with register file and pipeline
//
// one word in on the timeline channel (timeline_frame_i) gives one word out:
// audible_o, source_frame_o, fade_gain_o (Q1.16) and total_gain_o (Q8.16)
// silent frames come out with all fields zero
// the pipeline has two front stages, 32 divider stages (one quotient
// bit per stage for the loop modulo, the fade ratios share the first 16),
// and three back stages for source frame, fade product and clip gain
// throughput is one word per cycle while out_ready_i is high; every stage has its own valid bit
// and takes a new word whenever it is empty or its successor moves
// when out_ready_i is low, words pile up stage by stage and bubbles close;
// in_ready_o drops only once every stage holds a word
// registers sit on an apb port at byte address 4*index, pready is always
// high; write them only while no word is in flight
// reset empties the pipeline and loads register defaults (clip gain 1.0)
module clip_position_fade_gain (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cpf_pkg::ADDR_W-1:0]       paddr,
  input  logic [cpf_pkg::DATA_W-1:0]       pwdata,
  output logic [cpf_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cpf_pkg::FRAME_W-1:0]      timeline_frame_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             audible_o,
  output logic [cpf_pkg::FRAME_W-1:0]      source_frame_o,
  output logic [cpf_pkg::FADE_W-1:0]       fade_gain_o,
  output logic [cpf_pkg::GAIN_W-1:0]       total_gain_o
);
  import cpf_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  logic  f_valid, f_ready;
  item_t f_item;
  logic  v_valid, v_ready;
  item_t v_item;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfg_t'({{($bits(cfg_t)-GAIN_W){1'b0}}, UNITY_GAIN});
    end else if (wr_en) begin
      case (reg_idx)
        REG_CLIP_START:      cfg_q.clip_start      <= pwdata[FRAME_W-1:0];
        REG_SOURCE_OFFSET:   cfg_q.source_offset   <= pwdata[FRAME_W-1:0];
        REG_CLIP_LENGTH:     cfg_q.clip_length     <= pwdata[FRAME_W-1:0];
        REG_LOOP_ENABLE:     cfg_q.loop_enable     <= pwdata[0];
        REG_FADE_IN_LENGTH:  cfg_q.fade_in_length  <= pwdata[FRAME_W-1:0];
        REG_FADE_OUT_LENGTH: cfg_q.fade_out_length <= pwdata[FRAME_W-1:0];
        REG_BUFFER_FRAMES:   cfg_q.buffer_frames   <= pwdata[FRAME_W-1:0];
        REG_CLIP_GAIN:       cfg_q.clip_gain       <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_CLIP_START:      prdata = cfg_q.clip_start;
      REG_SOURCE_OFFSET:   prdata = cfg_q.source_offset;
      REG_CLIP_LENGTH:     prdata = cfg_q.clip_length;
      REG_LOOP_ENABLE:     prdata = {{(DATA_W-1){1'b0}}, cfg_q.loop_enable};
      REG_FADE_IN_LENGTH:  prdata = cfg_q.fade_in_length;
      REG_FADE_OUT_LENGTH: prdata = cfg_q.fade_out_length;
      REG_BUFFER_FRAMES:   prdata = cfg_q.buffer_frames;
      REG_CLIP_GAIN:       prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.clip_gain};
      default:             prdata = '0;
    endcase
  end

  cpf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .timeline_frame_i (timeline_frame_i),
    .out_valid_o      (f_valid),
    .out_ready_i      (f_ready),
    .out_item_o       (f_item)
  );

  cpf_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_item_i   (f_item),
    .out_valid_o (v_valid),
    .out_ready_i (v_ready),
    .out_item_o  (v_item)
  );

  cpf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (v_valid),
    .in_ready_o     (v_ready),
    .in_item_i      (v_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .audible_o      (audible_o),
    .source_frame_o (source_frame_o),
    .fade_gain_o    (fade_gain_o),
    .total_gain_o   (total_gain_o)
  );

endmodule

[hw/rtl/cpf_front.sv]
// front stages: position relative to clip start, range checks and divider setup
module cpf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cpf_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cpf_pkg::FRAME_W-1:0]     timeline_frame_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cpf_pkg::item_t                  out_item_o
);
  import cpf_pkg::*;

  logic               a_valid_q;
  logic               a_neg_q;
  logic [FRAME_W-1:0] a_rel_q;
  logic               b_valid_q;
  item_t              b_item_q;
  item_t              b_item_d;
  logic               a_ready;
  logic               b_ready;
  logic [FRAME_W-1:0] from_end;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    from_end          = cfg_i.clip_length - a_rel_q;
    b_item_d          = '0;
    b_item_d.wrap     = cfg_i.loop_enable && (cfg_i.clip_length != '0);
    b_item_d.silent   = a_neg_q || (!b_item_d.wrap && (a_rel_q >= cfg_i.clip_length));
    b_item_d.fin_use  = (cfg_i.fade_in_length != '0) && (a_rel_q < cfg_i.fade_in_length);
    b_item_d.fout_use = (cfg_i.fade_out_length != '0) && !cfg_i.loop_enable &&
                        (from_end < cfg_i.fade_out_length);
    b_item_d.rel      = a_rel_q;
    b_item_d.dvd      = a_rel_q;
    b_item_d.fin_rem  = a_rel_q;
    b_item_d.fout_rem = from_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_neg_q <= timeline_frame_i < cfg_i.clip_start;
      a_rel_q <= timeline_frame_i - cfg_i.clip_start;
    end
    if (b_ready && a_valid_q) begin
      b_item_q <= b_item_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;

endmodule

[hw/rtl/cpf_divider.sv]
// pipelined restoring divider: loop modulo and both fade ratios, one bit per stage
module cpf_divider (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cpf_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cpf_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cpf_pkg::item_t out_item_o
);
  import cpf_pkg::*;

  item_t                 item_q [DIV_STAGES];
  item_t                 src_item [DIV_STAGES];
  logic [DIV_STAGES-1:0] valid_q;
  logic [DIV_STAGES-1:0] src_valid;
  logic [DIV_STAGES:0]   rdy;

  assign rdy[DIV_STAGES] = out_ready_i;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src_item[k]  = in_item_i;
      assign src_valid[k] = in_valid_i;
    end else begin : g_next
      assign src_item[k]  = item_q[k-1];
      assign src_valid[k] = valid_q[k-1];
    end

    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= src_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_valid[k]) begin
        item_q[k] <= div_step(src_item[k], cfg_i, (k < FRAC_W));
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[DIV_STAGES-1];
  assign out_item_o  = item_q[DIV_STAGES-1];

endmodule

[hw/rtl/cpf_back.sv]
// back stages: source frame and buffer check, fade product, clip gain with saturation
module cpf_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cpf_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cpf_pkg::item_t                  in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            audible_o,
  output logic [cpf_pkg::FRAME_W-1:0]     source_frame_o,
  output logic [cpf_pkg::FADE_W-1:0]      fade_gain_o,
  output logic [cpf_pkg::GAIN_W-1:0]      total_gain_o
);
  import cpf_pkg::*;

  logic               c_valid_q, d_valid_q, e_valid_q;
  logic               c_ready, d_ready, e_ready;
  logic               c_silent_q, d_silent_q;
  logic [FRAME_W-1:0] c_src_q, d_src_q;
  logic [FADE_W-1:0]  c_fade_q, d_fade_q;
  logic               c_fout_use_q;
  logic [FRAC_W-1:0]  c_fout_q;
  logic               e_audible_q;
  logic [FRAME_W-1:0] e_src_q;
  logic [FADE_W-1:0]  e_fade_q;
  logic [GAIN_W-1:0]  e_total_q;

  logic [FRAME_W-1:0]        pos;
  logic [FRAME_W:0]          src_sum;
  logic [FADE_W+FRAC_W-1:0]  fade_prod;
  logic [FADE_W-1:0]         fade_d;
  logic [GAIN_W+FADE_W-1:0]  gain_prod;
  logic [GAIN_W:0]           gain_shift;
  logic [GAIN_W-1:0]         total_d;

  assign e_ready    = !e_valid_q || out_ready_i;
  assign d_ready    = !d_valid_q || e_ready;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  always_comb begin
    pos        = in_item_i.wrap ? in_item_i.mod_rem : in_item_i.rel;
    src_sum    = {1'b0, cfg_i.source_offset} + {1'b0, pos};
    fade_prod  = c_fade_q * c_fout_q;
    fade_d     = c_fout_use_q ? fade_prod[FRAC_W +: FADE_W] : c_fade_q;
    gain_prod  = cfg_i.clip_gain * d_fade_q;
    gain_shift = gain_prod[FRAC_W +: GAIN_W+1];
    total_d    = gain_shift[GAIN_W] ? {GAIN_W{1'b1}} : gain_shift[GAIN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      if (c_ready) c_valid_q <= in_valid_i;
      if (d_ready) d_valid_q <= c_valid_q;
      if (e_ready) e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_silent_q   <= in_item_i.silent || (src_sum >= {1'b0, cfg_i.buffer_frames});
      c_src_q      <= src_sum[FRAME_W-1:0];
      c_fade_q     <= in_item_i.fin_use ? {1'b0, in_item_i.fin_q} : UNITY_FADE;
      c_fout_use_q <= in_item_i.fout_use;
      c_fout_q     <= in_item_i.fout_q;
    end
    if (d_ready && c_valid_q) begin
      d_silent_q <= c_silent_q;
      d_src_q    <= c_src_q;
      d_fade_q   <= fade_d;
    end
    if (e_ready && d_valid_q) begin
      e_audible_q <= !d_silent_q;
      e_src_q     <= d_silent_q ? '0 : d_src_q;
      e_fade_q    <= d_silent_q ? '0 : d_fade_q;
      e_total_q   <= d_silent_q ? '0 : total_d;
    end
  end

  assign out_valid_o    = e_valid_q;
  assign audible_o      = e_audible_q;
  assign source_frame_o = e_src_q;
  assign fade_gain_o    = e_fade_q;
  assign total_gain_o   = e_total_q;

endmodule

[bench/clip_position_fade_gain_tb.sv]
// testbench for clip_position_fade_gain: config over apb, directed and random frames, predicted results
`timescale 1ns / 100ps

module clip_position_fade_gain_tb;
  import cpf_pkg::*;

  typedef struct packed {
    logic               audible;
    logic [FRAME_W-1:0] source_frame;
    logic [FADE_W-1:0]  fade_gain;
    logic [GAIN_W-1:0]  total_gain;
  } placement_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [FRAME_W-1:0] timeline_frame_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               audible_o;
  logic [FRAME_W-1:0] source_frame_o;
  logic [FADE_W-1:0]  fade_gain_o;
  logic [GAIN_W-1:0]  total_gain_o;

  cfg_t       shadow_cfg;
  placement_t placement_q[$];
  int         errors = 0;
  int         cycles = 0;
  bit         calm = 1'b0;

  clip_position_fade_gain dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("clip_position_fade_gain test failed");
      $finish;
    end
  end

  function automatic logic [FRAC_W-1:0] ratio_q16(logic [FRAME_W-1:0] num,
                                                  logic [FRAME_W-1:0] den);
    logic [FRAME_W+FRAC_W-1:0] n;
    n = {num, {FRAC_W{1'b0}}};
    return FRAC_W'(n / (FRAME_W+FRAC_W)'(den));
  endfunction

  function automatic placement_t place_frame(logic [FRAME_W-1:0] t);
    placement_t               p;
    logic [FRAME_W-1:0]       rel;
    logic [FRAME_W-1:0]       from_end;
    logic [FRAME_W:0]         src;
    logic [FADE_W-1:0]        fade;
    logic [FADE_W+FRAC_W-1:0] fprod;
    logic [GAIN_W+FADE_W-1:0] gprod;
    logic                     looping;
    p = '0;
    looping = shadow_cfg.loop_enable && shadow_cfg.clip_length != 0;
    if (t < shadow_cfg.clip_start) return p;
    rel = t - shadow_cfg.clip_start;
    if (looping) begin
      src = {1'b0, shadow_cfg.source_offset} + {1'b0, rel % shadow_cfg.clip_length};
    end else begin
      if (rel >= shadow_cfg.clip_length) return p;
      src = {1'b0, shadow_cfg.source_offset} + {1'b0, rel};
    end
    if (src >= {1'b0, shadow_cfg.buffer_frames}) return p;
    fade = UNITY_FADE;
    if (shadow_cfg.fade_in_length != 0 && rel < shadow_cfg.fade_in_length) begin
      fprod = fade * ratio_q16(rel, shadow_cfg.fade_in_length);
      fade = fprod[FRAC_W +: FADE_W];
    end
    from_end = shadow_cfg.clip_length - rel;
    if (shadow_cfg.fade_out_length != 0 && !shadow_cfg.loop_enable &&
        from_end < shadow_cfg.fade_out_length) begin
      fprod = fade * ratio_q16(from_end, shadow_cfg.fade_out_length);
      fade = fprod[FRAC_W +: FADE_W];
    end
    gprod = shadow_cfg.clip_gain * fade;
    p.audible = 1'b1;
    p.source_frame = src[FRAME_W-1:0];
    p.fade_gain = fade;
    if (|gprod[GAIN_W+FADE_W-1:GAIN_W+FRAC_W]) p.total_gain = {GAIN_W{1'b1}};
    else p.total_gain = gprod[FRAC_W +: GAIN_W];
    return p;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CLIP_START:      shadow_cfg.clip_start = val;
      REG_SOURCE_OFFSET:   shadow_cfg.source_offset = val;
      REG_CLIP_LENGTH:     shadow_cfg.clip_length = val;
      REG_LOOP_ENABLE:     shadow_cfg.loop_enable = val[0];
      REG_FADE_IN_LENGTH:  shadow_cfg.fade_in_length = val;
      REG_FADE_OUT_LENGTH: shadow_cfg.fade_out_length = val;
      REG_BUFFER_FRAMES:   shadow_cfg.buffer_frames = val;
      REG_CLIP_GAIN:       shadow_cfg.clip_gain = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_frame(logic [FRAME_W-1:0] t);
    if (!calm && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    timeline_frame_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    placement_q = {placement_q, place_frame(t)};
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (placement_q.size() != 0) @(negedge clk_i);
    repeat (45) @(negedge clk_i);
  endtask

  task automatic setup_clip(logic [31:0] st, logic [31:0] off, logic [31:0] len, bit lp,
                            logic [31:0] fin, logic [31:0] fout, logic [31:0] buf_len,
                            logic [31:0] gain);
    drain();
    write_reg(REG_CLIP_START, st);
    write_reg(REG_SOURCE_OFFSET, off);
    write_reg(REG_CLIP_LENGTH, len);
    write_reg(REG_LOOP_ENABLE, {31'b0, lp});
    write_reg(REG_FADE_IN_LENGTH, fin);
    write_reg(REG_FADE_OUT_LENGTH, fout);
    write_reg(REG_BUFFER_FRAMES, buf_len);
    write_reg(REG_CLIP_GAIN, gain);
  endtask

  function automatic logic [31:0] near_clip();
    logic [31:0] r;
    r = shadow_cfg.clip_length == 0 ? 32'd8 : shadow_cfg.clip_length;
    case ($urandom_range(5))
      0: return $urandom;
      1: return shadow_cfg.clip_start - $urandom_range(1, 4);
      default: return shadow_cfg.clip_start + $urandom_range(0, r + 4);
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_frame(32'd0);
    send_frame(32'hFFFF_FFFF);
  endtask

  task automatic test_directed;
    setup_clip(32'd100, 32'd5, 32'd50, 1'b0, 32'd10, 32'd10, 32'd1000, 32'h01_0000);
    send_frame(32'd99); send_frame(32'd100); send_frame(32'd105); send_frame(32'd110);
    send_frame(32'd140); send_frame(32'd141); send_frame(32'd149); send_frame(32'd150);
    setup_clip(32'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF,
               32'hFF_FFFF);
    send_frame(32'd14); send_frame(32'd15); send_frame(32'd16); send_frame(32'hFFFF_FFFE);
    setup_clip(32'd7, 32'd0, 32'd16, 1'b1, 32'd40, 32'd3, 32'd16, 32'h02_8000);
    send_frame(32'd7); send_frame(32'd22); send_frame(32'd23); send_frame(32'd50);
    send_frame(32'hFFFF_FFFF);
    setup_clip(32'd0, 32'd0, 32'd0, 1'b1, 32'd1, 32'd1, 32'd100, 32'd0);
    send_frame(32'd0); send_frame(32'd3);
    setup_clip(32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,
               32'h00_0001);
    send_frame(32'hFFFF_FFFF); send_frame(32'hFFFF_FFFE);
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 14; ph++) begin
      logic [31:0] len;
      len = ph % 4 == 0 ? $urandom : $urandom_range(1, 300);
      setup_clip(ph % 5 == 0 ? $urandom : $urandom_range(0, 1000),
                 ph % 3 == 0 ? $urandom : $urandom_range(0, 100), len, $urandom_range(1),
                 $urandom_range(2) == 0 ? 32'd0 : (ph % 4 == 1 ? $urandom : $urandom_range(1, 200)),
                 $urandom_range(2) == 0 ? 32'd0 : (ph % 4 == 2 ? $urandom : $urandom_range(1, 200)),
                 ph % 6 == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 500),
                 ph == 3 ? 32'hFF_FFFF : $urandom_range(0, 32'hFF_FFFF));
      if (ph == 12) calm = 1'b1;
      for (int k = 0; k < 100; k++) send_frame(near_clip());
    end
  endtask

  always @(negedge clk_i) begin
    if (!calm && $urandom_range(3) == 0) out_ready_i <= 1'b0;
    else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    placement_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {audible_o, source_frame_o, fade_gain_o, total_gain_o};
      if (placement_q.size() == 0) begin
        $display("%0t unexpected word %h", $realtime, got);
        errors++;
      end else begin
        want = placement_q.pop_front();
        if (want !== got) begin
          $display("%0t mismatch expected aud %b src %h fade %h gain %h,",
                   $realtime, want.audible, want.source_frame, want.fade_gain,
                   want.total_gain,
                   " actual aud %b src %h fade %h gain %h",
                   got.audible, got.source_frame, got.fade_gain, got.total_gain);
          errors++;
        end
      end
    end
  end

  initial begin
    shadow_cfg = '0;
    shadow_cfg.clip_gain = UNITY_GAIN;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_directed();
    test_random();
    drain();
    if (errors == 0 && placement_q.size() == 0) begin
      $display("clip_position_fade_gain test passed");
    end else begin
      $display("clip_position_fade_gain test failed");
    end
    $finish;
  end

endmodule

[clip_position_fade_gain.f]
hw/rtl/cpf_pkg.sv
hw/rtl/cpf_front.sv
hw/rtl/cpf_divider.sv
hw/rtl/cpf_back.sv
hw/rtl/clip_position_fade_gain.sv
bench/clip_position_fade_gain_tb.sv
